>>> rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the stepper speed sequencer
// Field widths, opcodes, register map, queue and divider structs, coil table.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int NUM_W   = 24;  // step_ticks_numerator width
  localparam int RPM_W   = 10;  // rpm limit width
  localparam int SPEED_W = 11;  // clamped signed speed width
  localparam int CMD_W   = 16;  // speed command width
  localparam int COIL_W  = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Input opcodes, carried on tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SPEED = 1'b1;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_MAX_RPM = 2'd0;
  localparam logic [1:0] REG_MIN_RPM = 2'd1;
  localparam logic [1:0] REG_NUMER   = 2'd2;

  localparam logic [RPM_W-1:0] MAX_RPM_RST = RPM_W'(375);
  localparam logic [RPM_W-1:0] MIN_RPM_RST = RPM_W'(60);
  localparam logic [NUM_W-1:0] NUMER_RST   = NUM_W'(300000);

  // Classified request passed from front to back
  typedef struct packed {
    logic                      is_cmd;
    logic signed [SPEED_W-1:0] speed;
  } queue_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [RPM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      step;
    logic [COIL_W-1:0]         coil;
  } result_t;

  // Full-step two-phase pattern: 5, 6, 10, 9
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      2'd0:    pat = 4'd5;
      2'd1:    pat = 4'd6;
      2'd2:    pat = 4'd10;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/stepper_speed_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_speed_sequencer: four-coil full-step stepper sequencer
// Ticks are executed at one per clock while no division is pending and the
// result stream is not stalled. A speed command with a nonzero clamped
// magnitude computes its step period in a bit-serial restoring divider, one
// quotient bit per cycle; a command that clamps to zero needs no division.
// Every request yields one result, in order.
// ----------------------------------------------------------------------------
module stepper_speed_sequencer import stp_pkg::*; #(
  parameter int WAIT_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CMD_W-1:0]  s_axis_tdata,   // [15:0] speed_command
  input  logic              s_axis_tuser,   // [0] opcode
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [3:0] coil_drive, [14:4] speed_now, [15] zero
  output logic              m_axis_tuser,   // [0] step_taken
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [RPM_W-1:0] max_rpm_q;
  logic [RPM_W-1:0] min_rpm_q;
  logic [NUM_W-1:0] numer_q;
  logic             wr_en;

  logic        q_push, q_pop, q_valid, q_full;
  queue_item_t q_in, q_out;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  result_t     result;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rpm_q <= MAX_RPM_RST;
      min_rpm_q <= MIN_RPM_RST;
      numer_q   <= NUMER_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAX_RPM: max_rpm_q <= pwdata[RPM_W-1:0];
        REG_MIN_RPM: min_rpm_q <= pwdata[RPM_W-1:0];
        REG_NUMER:   numer_q   <= pwdata[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_RPM: prdata = DATA_W'(max_rpm_q);
      REG_MIN_RPM: prdata = DATA_W'(min_rpm_q);
      REG_NUMER:   prdata = DATA_W'(numer_q);
      default:     prdata = '0;
    endcase
  end

  stp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .max_rpm_i     (max_rpm_q),
    .min_rpm_i     (min_rpm_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  stp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .item_o  (q_out)
  );

  stp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  stp_back #(
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_out),
    .q_pop_o    (q_pop),
    .numer_i    (numer_q),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tdata = {1'b0, result.speed, result.coil};
  assign m_axis_tuser = result.step;

endmodule

>>> rtl/stp_front.sv
// ----------------------------------------------------------------------------
// stp_front: request intake
// Accepts requests, clamps speed commands against the rpm limits and pushes
// the classified request into the queue.
// ----------------------------------------------------------------------------
module stp_front import stp_pkg::*; (
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [CMD_W-1:0]        s_axis_tdata,   // [15:0] speed_command
  input  logic                    s_axis_tuser,   // [0] opcode
  input  logic [RPM_W-1:0]        max_rpm_i,
  input  logic [RPM_W-1:0]        min_rpm_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output queue_item_t             q_item_o
);

  logic                      neg;
  logic [CMD_W-1:0]          mag;
  logic [RPM_W-1:0]          mag_clamp;
  logic signed [SPEED_W-1:0] speed_clamp;

  // -32768 maps to 0x8000, still correct as unsigned magnitude
  assign neg = s_axis_tdata[CMD_W-1];
  assign mag = neg ? CMD_W'(~s_axis_tdata + 1'b1) : s_axis_tdata;

  always_comb begin
    if (mag > CMD_W'(max_rpm_i)) begin
      mag_clamp = max_rpm_i;
    end else if (mag < CMD_W'(min_rpm_i)) begin
      mag_clamp = '0;
    end else begin
      mag_clamp = mag[RPM_W-1:0];
    end
    speed_clamp = neg ? -$signed({1'b0, mag_clamp}) : $signed({1'b0, mag_clamp});
  end

  assign s_axis_tready   = !q_full_i;
  assign q_push_o        = s_axis_tvalid && !q_full_i;
  assign q_item_o.is_cmd = (s_axis_tuser == OP_SPEED);
  assign q_item_o.speed  = speed_clamp;

endmodule

>>> rtl/stp_queue.sv
// ----------------------------------------------------------------------------
// stp_queue: two-entry request queue
// Decouples intake from execution; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module stp_queue import stp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  queue_item_t item_i,
  input  logic        pop_i,
  output logic        valid_o,
  output logic        full_o,
  output queue_item_t item_o
);

  queue_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign item_o  = mem_q[rd_ptr_q];

endmodule

>>> rtl/stp_div.sv
// ----------------------------------------------------------------------------
// stp_div: restoring divider for the step period
// One quotient bit per cycle; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module stp_div import stp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RPM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] dq_q, dq_d;
  logic [RPM_W-1:0] dvs_q, dvs_d;
  logic [RPM_W:0]   trial;
  logic             ge;

  // Shift the next dividend bit into the partial remainder
  assign trial = {rem_q, dq_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      dq_d   = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? RPM_W'(trial - {1'b0, dvs_q}) : trial[RPM_W-1:0];
      dq_d   = {dq_q[NUM_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = dq_q;

endmodule

>>> rtl/stp_back.sv
// ----------------------------------------------------------------------------
// stp_back: step execution
// Runs ticks against the wait counter and phase, applies speed commands (via
// the divider unless zero), and holds the result in an output register.
// ----------------------------------------------------------------------------
module stp_back import stp_pkg::*; #(
  parameter int WAIT_WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  queue_item_t      q_item_i,
  output logic             q_pop_o,
  input  logic [NUM_W-1:0] numer_i,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output result_t          m_result_o
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  logic signed [SPEED_W-1:0] speed_q, speed_d;
  logic signed [SPEED_W-1:0] pend_q, pend_d;
  logic [WAIT_WIDTH-1:0]     period_q, period_d;
  logic [WAIT_WIDTH-1:0]     wait_q, wait_d;
  logic [1:0]                phase_q, phase_d;
  logic [COIL_W-1:0]         coil_q, coil_d;
  logic                      out_valid_q, out_valid_d;
  result_t                   out_q, out_d;

  logic                  out_free;
  logic                  out_load;
  logic [WAIT_WIDTH-1:0] wait_dec;
  logic                  step;
  logic [RPM_W-1:0]      cmd_mag;
  logic [WAIT_WIDTH-1:0] quo_sat;

  assign out_free = !out_valid_q || m_ready_i;
  assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;
  assign step     = (wait_dec == '0) && (speed_q != '0);
  assign cmd_mag  = RPM_W'(q_item_i.speed[SPEED_W-1] ? -q_item_i.speed : q_item_i.speed);

  // Saturate the quotient to the counter width
  if (WAIT_WIDTH >= NUM_W) begin : g_wide
    assign quo_sat = WAIT_WIDTH'(div_rsp_i.quotient);
  end else begin : g_narrow
    assign quo_sat = (|div_rsp_i.quotient[NUM_W-1:WAIT_WIDTH]) ? '1 :
                     div_rsp_i.quotient[WAIT_WIDTH-1:0];
  end

  always_comb begin
    state_d   = state_q;
    speed_d   = speed_q;
    pend_d    = pend_q;
    period_d  = period_q;
    wait_d    = wait_q;
    phase_d   = phase_q;
    coil_d    = coil_q;
    out_load  = 1'b0;
    out_d     = out_q;
    q_pop_o   = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = numer_i;
    div_req_o.divisor  = cmd_mag;

    unique case (state_q)
      ST_RUN: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (!q_item_i.is_cmd) begin
            out_load = 1'b1;
            if (step) begin
              coil_d   = coil_pattern(phase_q);
              phase_d  = speed_q[SPEED_W-1] ? phase_q - 2'd1 : phase_q + 2'd1;
              wait_d   = period_q;
            end else begin
              wait_d   = wait_dec;
            end
            out_d.coil  = step ? coil_pattern(phase_q) : coil_q;
            out_d.step  = step;
            out_d.speed = speed_q;
          end else if (cmd_mag == '0) begin
            // zero speed needs no division
            out_load    = 1'b1;
            speed_d     = q_item_i.speed;
            period_d    = '0;
            out_d.coil  = coil_q;
            out_d.step  = 1'b0;
            out_d.speed = q_item_i.speed;
          end else begin
            div_req_o.start = 1'b1;
            pend_d          = q_item_i.speed;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!div_rsp_i.busy && out_free) begin
          out_load    = 1'b1;
          speed_d     = pend_q;
          period_d    = quo_sat;
          out_d.coil  = coil_q;
          out_d.step  = 1'b0;
          out_d.speed = pend_q;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      speed_q     <= '0;
      period_q    <= '0;
      wait_q      <= '0;
      phase_q     <= '0;
      coil_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      speed_q     <= speed_d;
      period_q    <= period_d;
      wait_q      <= wait_d;
      phase_q     <= phase_d;
      coil_q      <= coil_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  // Queue is drained only while no division is pending
  a_pop_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_RUN))
    else $error("request popped during division");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_rsp_i.busy)
    else $error("divider restarted while busy");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |=> (div_rsp_i.busy && state_q == ST_DIV))
    else $error("divider did not start");

  a_step_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.step) |-> (speed_q != '0))
    else $error("step taken at zero speed");

endmodule

>>> tb/stepper_speed_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_sequencer_tb: self-checking bench for the stepper sequencer
// Sends tick and speed requests on the request stream and predicts every
// result: clamped speed, step period, phase, wait counter and coil pattern.
// Each result is compared field by field, in order, under random stalls.
// ----------------------------------------------------------------------------
module stepper_speed_sequencer_tb;
  import stp_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped register slot
  localparam logic [COIL_W-1:0] COIL_SEQ [4] = '{4'd5, 4'd6, 4'd10, 4'd9};

  typedef struct packed {
    logic [COIL_W-1:0]         coil;
    logic                      step;
    logic signed [SPEED_W-1:0] speed;
  } coil_step_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [CMD_W-1:0]  s_axis_tdata = '0;   // [15:0] speed_command
  logic              s_axis_tuser = 1'b0; // [0] opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [3:0] coil_drive, [14:4] speed_now, [15] zero
  logic              m_axis_tuser;        // [0] step_taken
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Predictor state and register copies
  logic [RPM_W-1:0]          max_rpm_cfg;
  logic [RPM_W-1:0]          min_rpm_cfg;
  logic [NUM_W-1:0]          numer_cfg;
  logic signed [SPEED_W-1:0] speed_st;
  logic [NUM_W-1:0]          period_st;
  logic [1:0]                phase_st;
  logic [NUM_W-1:0]          wait_st;
  logic [COIL_W-1:0]         coil_st;

  coil_step_t coil_results_q[$];
  int         mismatch_count = 0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;

  stepper_speed_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic coil_step_t advance_sequencer(input logic op, input logic [CMD_W-1:0] cmd);
    coil_step_t r;
    logic       neg;
    logic [16:0] mag;
    r.step = 1'b0;
    if (op == OP_SPEED) begin
      neg = cmd[15];
      mag = neg ? (17'h10000 - {1'b0, cmd}) : {1'b0, cmd};
      // the upper limit wins over the lower one when they cross
      if (mag > max_rpm_cfg)
        mag = max_rpm_cfg;
      else if (mag < min_rpm_cfg)
        mag = '0;
      speed_st = neg ? SPEED_W'(-int'(mag)) : SPEED_W'(mag);
      period_st = (mag == 0) ? '0 : NUM_W'(int'(numer_cfg) / int'(mag));
    end else begin
      if (wait_st != 0)
        wait_st = wait_st - 1'b1;
      if (wait_st == 0 && speed_st != 0) begin
        coil_st = COIL_SEQ[phase_st];
        phase_st = (speed_st > 0) ? phase_st + 2'd1 : phase_st - 2'd1;
        wait_st = period_st;
        r.step = 1'b1;
      end
    end
    r.coil = coil_st;
    r.speed = speed_st;
    return r;
  endfunction

  // Receiver: random stalls unless switched off
  always @(posedge clk_i) begin
    m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 6);
  end

  always @(posedge clk_i) begin : check_results
    coil_step_t want;
    coil_step_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.coil = m_axis_tdata[3:0];
      got.speed = m_axis_tdata[14:4];
      got.step = m_axis_tuser;
      if (coil_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing pending: coil %h step %b speed %0d",
                   $time, got.coil, got.step, got.speed);
      end else begin
        want = coil_results_q.pop_front();
        if (got != want || m_axis_tdata[15] !== 1'b0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: coil %h/%h step %b/%b speed %0d/%0d pad %b (exp/got)",
                     $time, want.coil, got.coil, want.step, got.step,
                     want.speed, got.speed, m_axis_tdata[15]);
        end
      end
    end
  end

  task automatic send_req(input logic op, input logic [CMD_W-1:0] cmd);
    if (tx_idle_en && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cmd;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    coil_results_q.push_back(advance_sequencer(op, cmd));
  endtask

  task automatic tick();
    send_req(OP_TICK, CMD_W'($urandom));
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (coil_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_MAX_RPM: max_rpm_cfg = val[RPM_W-1:0];
      REG_MIN_RPM: min_rpm_cfg = val[RPM_W-1:0];
      REG_NUMER:   numer_cfg = val[NUM_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for the last result and let the design settle before new limits
  task automatic set_limits(input int max_v, input int min_v, input int numer_v);
    wait_results_done();
    repeat (30) @(posedge clk_i);
    write_reg(REG_MAX_RPM, DATA_W'(max_v));
    write_reg(REG_MIN_RPM, DATA_W'(min_v));
    write_reg(REG_NUMER, DATA_W'(numer_v));
  endtask

  function automatic logic [CMD_W-1:0] pick_speed_cmd();
    int m;
    case ($urandom_range(6))
      0: return CMD_W'($urandom);
      1: m = int'(max_rpm_cfg) + $urandom_range(4) - 2;
      2: m = int'(min_rpm_cfg) + $urandom_range(4) - 2;
      3: return '0;
      4: return 16'h8000;
      default: m = $urandom_range(1100);
    endcase
    if (m < 0) m = 0;
    return $urandom_range(1) ? CMD_W'(-m) : CMD_W'(m);
  endfunction

  task automatic test_reset_state();
    tick();
    tick();
  endtask

  task automatic test_speed_clamp();
    send_req(OP_SPEED, 16'h7FFF);
    tick();
    send_req(OP_SPEED, 16'h8000);
    send_req(OP_SPEED, 16'd59);
    send_req(OP_SPEED, 16'd60);
    send_req(OP_SPEED, 16'hFFC4);  // -60
    send_req(OP_SPEED, 16'd376);
    send_req(OP_SPEED, 16'hFE88);  // -376
    send_req(OP_SPEED, 16'hFFFF);
    send_req(OP_SPEED, 16'd0);
    tick();
  endtask

  task automatic test_step_direction();
    set_limits(1023, 0, 3);
    send_req(OP_SPEED, 16'd1);
    repeat (6) tick();
    send_req(OP_SPEED, 16'hFFFF);
    repeat (6) tick();
  endtask

  // Crossed limits and a numerator below the speed give a zero period
  task automatic test_crossed_limits();
    set_limits(100, 200, 1);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_req(OP_SPEED, 16'd150);
    repeat (3) tick();
    send_req(OP_SPEED, 16'd50);
    tick();
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12)
        send_req(OP_SPEED, pick_speed_cmd());
      else
        tick();
      // hold until everything is drained now and then
      if ($urandom_range(199) == 0)
        wait_results_done();
    end
  endtask

  task automatic test_random_settings();
    set_limits(375, 60, 300000);
    run_random(250);
    set_limits(1023, 0, 1);
    run_random(300);
    set_limits(1023, 0, 2000);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(300);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    set_limits(100, 200, 400);
    run_random(250);
    set_limits(0, 0, 16777215);
    run_random(150);
    set_limits(1023, 1023, 16777215);
    run_random(150);
    set_limits($urandom_range(1023), $urandom_range(64), $urandom_range(1, 3000));
    run_random(420);
  endtask

  initial begin
    max_rpm_cfg = MAX_RPM_RST;
    min_rpm_cfg = MIN_RPM_RST;
    numer_cfg = NUMER_RST;
    speed_st = '0;
    period_st = '0;
    phase_st = '0;
    wait_st = '0;
    coil_st = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_state();
    test_speed_clamp();
    test_step_direction();
    test_crossed_limits();
    test_random_settings();
    wait_results_done();
    repeat (40) @(posedge clk_i);
    if (coil_results_q.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
